/* design/sha256_pkg.sv */
// shared types, constants and round functions for the sha-256 hasher
package sha256_pkg;

    localparam int WORD_BITS  = 32;
    localparam int BLOCK_BITS = 512;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_ROUNDS = 64;
    localparam int NUM_CHAIN  = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;
    localparam logic [5:0] LAST_RND = 6'd63;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic start;
        logic reinit;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;

    localparam word_t INIT_WORDS [NUM_CHAIN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa98, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (WORD_BITS - n));
    endfunction

    function automatic word_t big_sigma0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* design/sha256_if.sv */
// valid/ready channels for message bytes and digest words
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* design/sha256_message_hasher.sv */
// sha-256 hasher top level: byte intake, padding, sequencing and digest output
//
// Message bytes enter on byte_ch, one per cycle while ready is high; the byte
// flagged last_byte ends the message. Each full 64-byte block runs through
// one shared compression round unit, one round per cycle, and intake pauses
// meanwhile. After the last byte the block adds the 0x80 pad, zeros and the
// 64-bit big-endian bit length, one byte per cycle, then compresses the one
// or two final blocks and sends the eight digest words on digest_ch, word 0
// first, with last_word on the eighth. Intake stays closed until the eighth
// word is taken, and the chaining words return to the initial hash values.
module sha256_message_hasher (
    input  logic          clk,
    input  logic          rst_n,
    sha256_in_if.sink     byte_ch,
    sha256_out_if.source  digest_ch
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [5:0]            pos_reg;
    logic [63:0]           bits_reg;
    logic                  final_reg;
    logic                  pad80_reg;
    logic                  len_reg;
    logic                  finish_reg;
    logic [2:0]            widx_reg;
    logic [BLOCK_BITS-1:0] block_reg;

    logic       wr_en;
    logic [7:0] wr_byte;
    logic       len_now;
    logic [2:0] len_sel;
    ctl_t       ctl;
    sts_t       sts;
    word_t      chain [NUM_CHAIN];

    sha256_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .block (block_reg),
        .sts   (sts),
        .chain (chain)
    );

    assign len_now = pad80_reg && (len_reg || pos_reg == LEN_POS);
    assign len_sel = LAST_IDX - pos_reg[2:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = byte_ch.data_byte;
        if (state_reg == ST_IDLE)
        begin
            wr_en = byte_ch.valid;
        end
        else if (state_reg == ST_PAD)
        begin
            wr_en = 1'b1;
            priority if (!pad80_reg)
            begin
                wr_byte = PAD_BYTE;
            end
            else if (len_now)
            begin
                wr_byte = bits_reg[{len_sel, 3'b000} +: 8];
            end
            else
            begin
                wr_byte = 8'h00;
            end
        end
    end

    assign ctl.start  = (state_reg == ST_START);
    assign ctl.reinit = (state_reg == ST_OUT) && digest_ch.ready && (widx_reg == LAST_IDX);

    assign byte_ch.ready         = (state_reg == ST_IDLE);
    assign digest_ch.valid       = (state_reg == ST_OUT);
    assign digest_ch.digest_word = chain[widx_reg];
    assign digest_ch.word_index  = widx_reg;
    assign digest_ch.last_word   = (widx_reg == LAST_IDX);

    // block buffer as a byte shift line, first byte ends up most significant
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            block_reg <= {block_reg[BLOCK_BITS-9:0], wr_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            bits_reg   <= '0;
            final_reg  <= 1'b0;
            pad80_reg  <= 1'b0;
            len_reg    <= 1'b0;
            finish_reg <= 1'b0;
            widx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (byte_ch.valid)
                    begin
                        pos_reg    <= pos_reg + 6'd1;
                        bits_reg   <= bits_reg + 64'd8;
                        final_reg  <= byte_ch.last_byte;
                        pad80_reg  <= 1'b0;
                        len_reg    <= 1'b0;
                        finish_reg <= 1'b0;
                        if (pos_reg == LAST_POS)
                        begin
                            state_reg <= ST_START;
                        end
                        else if (byte_ch.last_byte)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (!pad80_reg)
                    begin
                        pad80_reg <= 1'b1;
                    end
                    else if (pos_reg == LEN_POS)
                    begin
                        len_reg <= 1'b1;
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        finish_reg <= len_now;
                        state_reg  <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (sts.done)
                    begin
                        widx_reg <= '0;
                        priority if (finish_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (final_reg)
                        begin
                            state_reg <= ST_PAD;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (digest_ch.ready)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == LAST_IDX)
                        begin
                            bits_reg   <= '0;
                            final_reg  <= 1'b0;
                            finish_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_ch.ready && digest_ch.valid))
        else $error("intake open while digest pending");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !sts.busy)
        else $error("compression started while busy");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> state_reg == ST_WAIT)
        else $error("compression finished outside wait");

    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_ch.valid) |-> (pos_reg == '0 && widx_reg == '0))
        else $error("digest output without block alignment");
`endif

endmodule

/* design/sha256_core.sv */
// sha-256 compression, one round per cycle, holding the chaining words
module sha256_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sha256_pkg::ctl_t                      ctl,
    input  logic [sha256_pkg::BLOCK_BITS-1:0]     block,
    output sha256_pkg::sts_t                      sts,
    output sha256_pkg::word_t                     chain [sha256_pkg::NUM_CHAIN]
);
    import sha256_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    core_state_t state_reg;
    logic [5:0]  round_reg;
    logic        done_reg;
    word_t       chain_reg [NUM_CHAIN];
    word_t       v_reg [NUM_CHAIN];
    word_t       w_reg [NUM_WORDS];

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;
    word_t w_next;

    always_comb
    begin
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[round_reg] + w_reg[0];
        t2     = big_sigma0(v_reg[0]) + maj;
        w_next = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                chain_reg[i] <= INIT_WORDS[i];
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (ctl.reinit)
                    begin
                        for (int i = 0; i < NUM_CHAIN; i++)
                        begin
                            chain_reg[i] <= INIT_WORDS[i];
                        end
                    end
                    if (ctl.start)
                    begin
                        round_reg <= '0;
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LAST_RND)
                    begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    for (int i = 0; i < NUM_CHAIN; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && ctl.start)
        begin
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                w_reg[i] <= block[BLOCK_BITS-1-WORD_BITS*i -: WORD_BITS];
            end
        end
        else if (state_reg == C_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < NUM_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[NUM_WORDS-1] <= w_next;
        end
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = done_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAIN; i++)
        begin
            chain[i] = chain_reg[i];
        end
    end

endmodule
